@@ rtl/sktl_pkg.sv @@
// shared constants and types for the sorted key table lookup unit
// no dependencies
`default_nettype none
package sktl_pkg;
	localparam int TableDepth = 1024;
	localparam int AddrW = $clog2(TableDepth);
	localparam int CntW = AddrW + 1;
	localparam int KeyW = 64;
	localparam int CodeW = 16;
	localparam int ScoreW = 14;
	localparam int TotW = CodeW + AddrW;
	localparam int EntryW = KeyW + 4 * CodeW;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_FIND = 2'd1,
		OP_BEST = 2'd2,
		OP_LEARN = 2'd3
	} op_t;

	localparam logic REG_ENTRIES = 1'b0;
	localparam logic REG_THRESH = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic latch;      // capture input transaction
		logic srch_init;
		logic srch_step;  // consume read data for one search step
		logic rd_lo;      // read at lo
		logic rd_scan;    // read at scan pointer
		logic scan_init;
		logic scan_adv;
		logic tot_acc;
		logic div_init;
		logic div_step;
		logic best_upd;
		logic learn_wr;
		logic load_wr;
		logic fin_search;
		logic done;
	} ctl_t;

	typedef struct packed {
		logic srch_busy;  // lo < hi
		logic empty;
		logic scan_match; // read entry matches key and in range
		logic move_hit;
		logic div_done;
		logic slot_ok;
	} sts_t;
endpackage
`default_nettype wire

@@ rtl/sktl_ram.sv @@
// generic single port ram with registered read
// no dependencies
`default_nettype none
module sktl_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

@@ rtl/sktl_datapath.sv @@
// datapath: table memory, search pointers, scan, divider and result
// depends on sktl_pkg and sktl_ram
`default_nettype none
module sktl_datapath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  sktl_pkg::ctl_t                    ctl,
	output sktl_pkg::sts_t                    sts,
	input  wire logic [1:0]                   op,
	input  wire logic [sktl_pkg::AddrW-1:0]   slot,
	input  wire logic [sktl_pkg::KeyW-1:0]    key,
	input  wire logic [sktl_pkg::CodeW-1:0]   move_code,
	input  wire logic [sktl_pkg::CodeW-1:0]   weight_count,
	input  wire logic [sktl_pkg::CodeW-1:0]   games_count,
	input  wire logic [sktl_pkg::CodeW-1:0]   points_count,
	input  wire logic signed [1:0]            outcome,
	input  wire logic [sktl_pkg::CntW-1:0]    n_cfg,
	input  wire logic [9:0]                   thresh,
	output logic                              found,
	output logic [sktl_pkg::CntW-1:0]         position,
	output logic [sktl_pkg::CodeW-1:0]        chosen_move,
	output logic [sktl_pkg::ScoreW-1:0]       chosen_score
);
	localparam int AW = sktl_pkg::AddrW;
	localparam int NW = sktl_pkg::CntW;
	localparam int CW = sktl_pkg::CodeW;
	localparam int KW = sktl_pkg::KeyW;
	localparam int TW = sktl_pkg::TotW;
	localparam int DW = CW + 14;

	logic [1:0]    op_q;
	logic [AW-1:0] slot_q;
	logic [KW-1:0] key_q;
	logic [CW-1:0] mv_q, wt_q, gm_q, pt_q;
	logic signed [1:0] oc_q;
	logic [NW-1:0] n_q, lo_q, hi_q, scan_q, first_q;
	logic [TW-1:0] tot_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [4:0]    dcnt_q;
	logic [CW-1:0] cur_mv_q;

	logic          we;
	logic [AW-1:0] addr;
	logic [sktl_pkg::EntryW-1:0] wdata, rdata;
	logic [KW-1:0] r_key;
	logic [CW-1:0] r_mv, r_wt, r_gm, r_pt;
	logic [NW-1:0] mid;
	logic [NW:0]   mid_sum;

	assign {r_key, r_mv, r_wt, r_gm, r_pt} = rdata;
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = mid_sum[NW:1];

	always_comb begin
		we = 1'b0;
		addr = scan_q[AW-1:0];
		wdata = {r_key, r_mv, r_wt, gm_q, pt_q};
		if (ctl.load_wr) begin
			we = sts.slot_ok;
			addr = slot_q;
			wdata = {key_q, mv_q, wt_q, gm_q, pt_q};
		end else if (ctl.learn_wr) begin
			we = 1'b1;
			addr = scan_q[AW-1:0];
			wdata = {r_key, r_mv, r_wt, r_gm + CW'(1),
				r_pt + CW'(oc_q) + CW'(1)};
		end else if (ctl.rd_lo) begin
			addr = lo_q[AW-1:0];
		end else if (!ctl.rd_scan) begin
			addr = mid[AW-1:0];
		end
	end

	sktl_ram #(.Width(sktl_pkg::EntryW), .Depth(sktl_pkg::TableDepth)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	logic [DW-1:0] rem_sh;
	logic [DW:0]   trial;
	assign rem_sh = {rem_q[DW-2:0], quo_q[DW-1]};
	assign trial = {1'b0, rem_sh} - {{(DW+1-TW){1'b0}}, tot_q};

	assign sts.srch_busy = lo_q < hi_q;
	assign sts.empty = n_q == '0;
	assign sts.scan_match = (scan_q < n_q) && (r_key == key_q);
	assign sts.move_hit = r_mv == mv_q;
	assign sts.div_done = dcnt_q == '0;
	assign sts.slot_ok = 1'b1;

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			op_q <= op;
			slot_q <= slot;
			key_q <= key;
			mv_q <= move_code;
			wt_q <= weight_count;
			gm_q <= games_count;
			pt_q <= points_count;
			oc_q <= outcome;
			n_q <= (n_cfg > NW'(sktl_pkg::TableDepth)) ? NW'(sktl_pkg::TableDepth) : n_cfg;
		end
		if (ctl.srch_init) begin
			lo_q <= '0;
			hi_q <= sts.empty ? '0 : n_q - NW'(1);
		end
		if (ctl.srch_step) begin
			if (key_q <= r_key) hi_q <= mid;
			else lo_q <= mid + NW'(1);
		end
		if (ctl.fin_search) begin
			first_q <= (!sts.empty && r_key == key_q) ? lo_q : n_q;
			scan_q <= (!sts.empty && r_key == key_q) ? lo_q : n_q;
			tot_q <= '0;
		end
		if (ctl.scan_init) scan_q <= first_q;
		if (ctl.scan_adv) scan_q <= scan_q + NW'(1);
		if (ctl.tot_acc) tot_q <= tot_q + TW'(r_wt);
		if (ctl.div_init) begin
			rem_q <= '0;
			quo_q <= DW'(r_wt) * DW'(10000);
			cur_mv_q <= r_mv;
			dcnt_q <= 5'(DW);
		end
		if (ctl.div_step) begin
			dcnt_q <= dcnt_q - 5'd1;
			if (!trial[DW]) rem_q <= trial[DW-1:0];
			else rem_q <= rem_sh;
			quo_q <= {quo_q[DW-2:0], ~trial[DW]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found <= 1'b0;
			position <= '0;
			chosen_move <= '0;
			chosen_score <= '0;
		end else begin
			if (ctl.latch) begin
				found <= 1'b0;
				position <= '0;
				chosen_move <= '0;
				chosen_score <= '0;
			end
			if (ctl.load_wr) begin
				found <= 1'b1;
				position <= NW'(slot_q);
			end
			if (ctl.fin_search) begin
				if (op_q == sktl_pkg::OP_LEARN) position <= n_q;
				else position <= (!sts.empty && r_key == key_q) ? lo_q : n_q;
				if (op_q == sktl_pkg::OP_FIND) found <= !sts.empty && r_key == key_q;
			end
			if (ctl.learn_wr) begin
				found <= 1'b1;
				position <= scan_q;
			end
			if (ctl.best_upd && cur_mv_q != '0 && tot_q != '0
				&& quo_q > DW'(thresh) * DW'(10)
				&& quo_q > DW'(chosen_score)) begin
				chosen_score <= quo_q[sktl_pkg::ScoreW-1:0];
				chosen_move <= cur_mv_q;
				found <= 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/sktl_ctrl.sv @@
// controller state machine for the lookup unit
// depends on sktl_pkg
`default_nettype none
module sktl_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [1:0]     op,
	input  sktl_pkg::sts_t      sts,
	output sktl_pkg::ctl_t      ctl,
	output logic                busy,
	output logic                done
);
	typedef enum logic [3:0] {
		S_IDLE, S_DISP, S_SRD, S_SSTEP, S_LRD, S_LCHK, S_TRD, S_TCHK,
		S_BRD, S_BCHK, S_DIV, S_BUPD, S_XRD, S_XCHK, S_DONE
	} state_t;
	state_t state_q;
	logic [1:0] op_q;

	always_comb begin
		ctl = '0;
		ctl.latch = (state_q == S_IDLE) && start;
		case (state_q)
			S_DISP: begin
				if (op_q == sktl_pkg::OP_LOAD) ctl.load_wr = 1'b1;
				else ctl.srch_init = 1'b1;
			end
			S_SSTEP: ctl.srch_step = sts.srch_busy;
			S_LRD: ctl.rd_lo = 1'b1;
			S_LCHK: ctl.fin_search = 1'b1;
			S_TRD: ctl.rd_scan = 1'b1;
			S_TCHK: begin
				ctl.rd_scan = 1'b1;
				if (sts.scan_match) begin
					ctl.tot_acc = 1'b1;
					ctl.scan_adv = 1'b1;
				end else begin
					ctl.scan_init = 1'b1;
				end
			end
			S_BRD: ctl.rd_scan = 1'b1;
			S_BCHK: begin
				ctl.rd_scan = 1'b1;
				ctl.div_init = sts.scan_match;
			end
			S_DIV: begin
				ctl.rd_scan = 1'b1;
				ctl.div_step = !sts.div_done;
			end
			S_BUPD: begin
				ctl.rd_scan = 1'b1;
				ctl.best_upd = 1'b1;
				ctl.scan_adv = 1'b1;
			end
			S_XRD: ctl.rd_scan = 1'b1;
			S_XCHK: begin
				ctl.rd_scan = 1'b1;
				if (sts.scan_match && sts.move_hit) ctl.learn_wr = 1'b1;
				else if (sts.scan_match) ctl.scan_adv = 1'b1;
			end
			S_DONE: ctl.done = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= sktl_pkg::OP_LOAD;
			busy <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: if (start) begin
					state_q <= S_DISP;
					op_q <= op;
					busy <= 1'b1;
				end
				S_DISP: state_q <= (op_q == sktl_pkg::OP_LOAD) ? S_DONE : S_SRD;
				S_SRD: state_q <= sts.srch_busy ? S_SSTEP : S_LRD;
				S_SSTEP: state_q <= S_SRD;
				S_LRD: state_q <= S_LCHK;
				S_LCHK: begin
					if (op_q == sktl_pkg::OP_BEST) state_q <= S_TRD;
					else if (op_q == sktl_pkg::OP_LEARN) state_q <= S_XRD;
					else state_q <= S_DONE;
				end
				S_TRD: state_q <= S_TCHK;
				S_TCHK: state_q <= sts.scan_match ? S_TRD : S_BRD;
				S_BRD: state_q <= S_BCHK;
				S_BCHK: state_q <= sts.scan_match ? S_DIV : S_DONE;
				S_DIV: if (sts.div_done) state_q <= S_BUPD;
				S_BUPD: state_q <= S_BRD;
				S_XRD: state_q <= S_XCHK;
				S_XCHK: state_q <= (sts.scan_match && !sts.move_hit) ? S_XRD : S_DONE;
				S_DONE: begin
					state_q <= S_IDLE;
					busy <= 1'b0;
					done <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("start not taken");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
endmodule
`default_nettype wire

@@ rtl/sorted_key_table_lookup_unit.sv @@
// top level of the sorted key table lookup unit
// depends on sktl_pkg, sktl_ctrl, sktl_datapath, sktl_ram
// usage:
//  raise start with op and operand fields while busy is low; the transaction
//  is taken at that edge and busy rises the next cycle.
//  done strobes for one cycle with found, position, chosen_move, chosen_score.
//  the receiver cannot hold results off.
//  the next transaction can be taken at the edge that ends the done cycle.
//  load writes the entry at slot. find runs a binary search over the n
//  entries in use, with the single table memory port read once per search
//  step. best then scans the matching entries once to sum their weights,
//  then scans them again with a shift-subtract divide per matching entry.
//  learn scans the matching entries until the move matches and updates it.
//  entries_in_use (index 0) and score_threshold (index 1) are written by
//  cfg_we; the user must write them only while idle, which the block itself
//  does not enforce. reset clears both registers and the controller; table
//  contents are undefined until loaded.
`default_nettype none
module sorted_key_table_lookup_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	output logic                             done,
	input  wire logic [1:0]                  op,
	input  wire logic [sktl_pkg::AddrW-1:0]  slot,
	input  wire logic [sktl_pkg::KeyW-1:0]   key,
	input  wire logic [sktl_pkg::CodeW-1:0]  move_code,
	input  wire logic [sktl_pkg::CodeW-1:0]  weight_count,
	input  wire logic [sktl_pkg::CodeW-1:0]  games_count,
	input  wire logic [sktl_pkg::CodeW-1:0]  points_count,
	input  wire logic signed [1:0]           outcome,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [10:0]                 cfg_data,
	output logic                             found,
	output logic [sktl_pkg::CntW-1:0]        position,
	output logic [sktl_pkg::CodeW-1:0]       chosen_move,
	output logic [sktl_pkg::ScoreW-1:0]      chosen_score
);
	sktl_pkg::ctl_t ctl;
	sktl_pkg::sts_t sts;
	logic [10:0] n_q;
	logic [9:0]  th_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			th_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == sktl_pkg::REG_ENTRIES) n_q <= cfg_data;
			else th_q <= cfg_data[9:0];
		end
	end

	sktl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .op(op), .sts(sts),
		.ctl(ctl), .busy(busy), .done(done)
	);

	sktl_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts), .op(op), .slot(slot),
		.key(key), .move_code(move_code), .weight_count(weight_count),
		.games_count(games_count), .points_count(points_count),
		.outcome(outcome), .n_cfg(n_q), .thresh(th_q), .found(found),
		.position(position), .chosen_move(chosen_move), .chosen_score(chosen_score)
	);
endmodule
`default_nettype wire
